// ===== src/pmr_pkg.sv =====
// Package for the plot marker rasterizer: constants, types, marker offset tables.
`default_nettype none
package pmr_pkg;

    // Default page geometry
    localparam int C_PLOT_HEIGHT = 512;
    localparam int C_TOP_MARGIN  = 16;
    localparam int C_LEFT_MARGIN = 16;
    localparam int C_BAND_ROWS   = 256;
    localparam int C_BAND_COUNT  = 3;
    localparam int C_COL_UNITS   = 128;
    localparam int C_COL_FACTOR  = 6;

    // Largest dot pattern (box outline)
    localparam int C_MAX_DOTS = 20;

    // Width of the signed page coordinate math
    localparam int C_CW = 14;

    typedef enum logic [2:0] {
        SHP_SQUARE = 3'd0,
        SHP_XMARK  = 3'd1,
        SHP_POINT  = 3'd2,
        SHP_PLUS   = 3'd3,
        SHP_BOX    = 3'd4
    } t_shape;

    // Point word passed from the input stage to the dot walker
    typedef struct packed {
        logic signed [11:0] row;
        logic signed [11:0] col;
    } t_pt_word;

    // One marker dot offset
    typedef struct packed {
        logic              ok;
        logic signed [2:0] dr;
        logic signed [2:0] dc;
    } t_offs;

    // Offset tables in emission order, padded to the largest pattern
    localparam int SQ_DR [C_MAX_DOTS] = '{-1, -1, -1, 0, 0, 0, 1, 1, 1,
                                          0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0};
    localparam int SQ_DC [C_MAX_DOTS] = '{-1, 0, 1, -1, 0, 1, -1, 0, 1,
                                          0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0};
    localparam int XM_DR [C_MAX_DOTS] = '{1, 1, -1, -1, 0,
                                          0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0};
    localparam int XM_DC [C_MAX_DOTS] = '{-1, 1, -1, 1, 0,
                                          0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0};
    localparam int PL_DR [C_MAX_DOTS] = '{0, 0, 1, -1, 0,
                                          0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0};
    localparam int PL_DC [C_MAX_DOTS] = '{1, -1, 0, 0, 0,
                                          0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0};
    // Box: sides first, then top and bottom rows; corners appear twice
    localparam int BX_DR [C_MAX_DOTS] = '{-2, -2, -1, -1, 0, 0, 1, 1, 2, 2,
                                          2, -2, 2, -2, 2, -2, 2, -2, 2, -2};
    localparam int BX_DC [C_MAX_DOTS] = '{-2, 2, -2, 2, -2, 2, -2, 2, -2, 2,
                                          -2, -2, -1, -1, 0, 0, 1, 1, 2, 2};

    // Offset of dot k of the given shape; ok is low past the pattern end
    function automatic t_offs pmr_offset(t_shape shape, logic [4:0] k);
        t_offs o;
        o = '0;
        case (shape)
            SHP_SQUARE: begin
                o.ok = (k < 5'd9);
                o.dr = 3'(SQ_DR[k]);
                o.dc = 3'(SQ_DC[k]);
            end
            SHP_XMARK: begin
                o.ok = (k < 5'd5);
                o.dr = 3'(XM_DR[k]);
                o.dc = 3'(XM_DC[k]);
            end
            SHP_POINT: begin
                o.ok = (k == 5'd0);
            end
            SHP_PLUS: begin
                o.ok = (k < 5'd5);
                o.dr = 3'(PL_DR[k]);
                o.dc = 3'(PL_DC[k]);
            end
            SHP_BOX: begin
                o.ok = (k < 5'd20);
                o.dr = 3'(BX_DR[k]);
                o.dc = 3'(BX_DC[k]);
            end
            default: begin
                o = '0;
            end
        endcase
        return o;
    endfunction

endpackage
`default_nettype wire

// ===== src/pmr_ifs.sv =====
// Stream interfaces for plot points in and page dots out.
`default_nettype none
interface pmr_pt_if;
    logic               valid;
    logic               ready;
    logic signed [11:0] point_row;
    logic signed [11:0] point_col;
    logic               first_point;

    modport source (output valid, output point_row, output point_col,
                    output first_point, input ready);
    modport sink   (input valid, input point_row, input point_col,
                    input first_point, output ready);
endinterface

interface pmr_dot_if;
    logic       valid;
    logic       ready;
    logic [9:0] dot_row;
    logic [9:0] dot_col;
    logic [1:0] band;
    logic       last_dot;

    modport source (output valid, output dot_row, output dot_col,
                    output band, output last_dot, input ready);
    modport sink   (input valid, input dot_row, input dot_col,
                    input band, input last_dot, output ready);
endinterface
`default_nettype wire

// ===== src/pmr_in_stage.sv =====
// Input register with repeated-point filter and previous-point state.
`default_nettype none
module pmr_in_stage (
    input  wire              i_clk,
    input  wire              i_rst_n,
    pmr_pt_if.sink           i_pt,
    output logic             o_vld,
    output pmr_pkg::t_pt_word o_word,
    input  wire              i_rdy
);
    import pmr_pkg::*;

    logic     r_vld;
    t_pt_word r_word;
    logic [11:0] r_prev_row;
    logic [11:0] r_prev_col;

    logic accept;
    logic draw;

    // Take a word whenever the register is empty or being drained
    assign i_pt.ready = !r_vld || i_rdy;
    assign accept     = i_pt.valid && i_pt.ready;

    // A repeat of the previous point is dropped unless it starts a set
    assign draw = i_pt.first_point ||
                  (i_pt.point_row != r_prev_row) || (i_pt.point_col != r_prev_col);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld      <= 1'b0;
            r_prev_row <= '0;
            r_prev_col <= '0;
        end else if (accept) begin
            r_vld      <= draw;
            r_prev_row <= i_pt.point_row;
            r_prev_col <= i_pt.point_col;
        end else if (i_rdy) begin
            r_vld <= 1'b0;
        end
    end

    // Payload, no reset
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_word.row <= i_pt.point_row;
            r_word.col <= i_pt.point_col;
        end
    end

    assign o_vld  = r_vld;
    assign o_word = r_word;

endmodule
`default_nettype wire

// ===== src/pmr_dot_walker.sv =====
// Expands a point into its marker's on-page dot words, one per cycle unless stalled.
`default_nettype none
module pmr_dot_walker #(
    parameter int PLOT_HEIGHT = pmr_pkg::C_PLOT_HEIGHT,
    parameter int TOP_MARGIN  = pmr_pkg::C_TOP_MARGIN,
    parameter int LEFT_MARGIN = pmr_pkg::C_LEFT_MARGIN,
    parameter int BAND_ROWS   = pmr_pkg::C_BAND_ROWS,
    parameter int BAND_COUNT  = pmr_pkg::C_BAND_COUNT,
    parameter int COL_UNITS   = pmr_pkg::C_COL_UNITS
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire pmr_pkg::t_shape i_shape,
    input  wire               i_vld,
    input  wire pmr_pkg::t_pt_word i_word,
    output logic              o_rdy,
    pmr_dot_if.source         o_dot
);
    import pmr_pkg::*;

    localparam logic signed [C_CW-1:0] C_ROW_BASE = C_CW'(PLOT_HEIGHT + TOP_MARGIN);
    localparam logic signed [C_CW-1:0] C_COL_BASE = C_CW'(LEFT_MARGIN);
    localparam logic signed [C_CW-1:0] C_ROW_MAX  = C_CW'(BAND_ROWS * BAND_COUNT);
    localparam logic signed [C_CW-1:0] C_COL_MAX  = C_CW'(COL_UNITS * C_COL_FACTOR);
    localparam logic signed [C_CW-1:0] C_BAND1    = C_CW'(BAND_ROWS);
    localparam logic signed [C_CW-1:0] C_BAND2    = C_CW'(2 * BAND_ROWS);

    logic [C_MAX_DOTS-1:0]   r_mask;
    logic signed [C_CW-1:0]  r_base_row;
    logic signed [C_CW-1:0]  r_base_col;
    logic                    r_out_vld;
    logic [9:0]              r_dot_row;
    logic [9:0]              r_dot_col;
    logic [1:0]              r_band;
    logic                    r_last;

    logic [C_MAX_DOTS-1:0]   n_mask;
    logic signed [C_CW-1:0]  ld_row;
    logic signed [C_CW-1:0]  ld_col;
    logic signed [C_CW-1:0]  rr [5];
    logic signed [C_CW-1:0]  cc [5];
    logic [4:0]              row_ok;
    logic [4:0]              col_ok;
    logic [C_MAX_DOTS-1:0]   ld_mask;
    t_offs                   ld_off;

    logic [4:0]              idx;
    logic [C_MAX_DOTS-1:0]   rest;
    t_offs                   cur_off;
    logic signed [C_CW-1:0]  dot_r;
    logic signed [C_CW-1:0]  dot_c;
    logic [1:0]              band;
    logic                    out_free;
    logic                    emit;
    logic                    load;
    logic                    walk_free;

    // Base page position of the point, before the marker offset
    assign ld_row = C_ROW_BASE - {{(C_CW-12){i_word.row[11]}}, i_word.row};
    assign ld_col = {{(C_CW-12){i_word.col[11]}}, i_word.col} + C_COL_BASE;

    // Page bounds per offset -2..2, then the kept-dot mask of the shape
    always_comb begin
        ld_off = '0;
        for (int i = 0; i < 5; i++) begin
            rr[i]     = ld_row + C_CW'(2 - i);
            cc[i]     = ld_col + C_CW'(i - 2);
            row_ok[i] = !rr[i][C_CW-1] && (rr[i] <= C_ROW_MAX);
            col_ok[i] = !cc[i][C_CW-1] && (cc[i] <= C_COL_MAX);
        end
        for (int k = 0; k < C_MAX_DOTS; k++) begin
            ld_off     = pmr_offset(i_shape, 5'(k));
            // offset -2..2 maps to bound slot 0..4, taken as an unsigned index
            ld_mask[k] = ld_off.ok && row_ok[3'($unsigned(ld_off.dr) + 3'd2)]
                                   && col_ok[3'($unsigned(ld_off.dc) + 3'd2)];
        end
    end

    // Lowest pending dot goes next
    always_comb begin
        idx = '0;
        for (int k = C_MAX_DOTS - 1; k >= 0; k--) begin
            if (r_mask[k]) begin
                idx = 5'(k);
            end
        end
    end

    assign rest    = r_mask & ~(C_MAX_DOTS'(1) << idx);
    assign cur_off = pmr_offset(i_shape, idx);
    assign dot_r   = r_base_row - {{(C_CW-3){cur_off.dr[2]}}, cur_off.dr};
    assign dot_c   = r_base_col + {{(C_CW-3){cur_off.dc[2]}}, cur_off.dc};

    // Strip index by page row
    always_comb begin
        priority if (dot_r < C_BAND1) begin
            band = 2'd0;
        end else if (dot_r < C_BAND2) begin
            band = 2'd1;
        end else begin
            band = 2'd2;
        end
    end

    // Handshake between walker, input stage and output register
    assign out_free  = !r_out_vld || o_dot.ready;
    assign emit      = (r_mask != '0) && out_free;
    assign walk_free = (r_mask == '0) || (emit && (rest == '0));
    assign load      = i_vld && walk_free;
    assign o_rdy     = walk_free;

    always_comb begin
        if (load) begin
            n_mask = ld_mask;
        end else if (emit) begin
            n_mask = rest;
        end else begin
            n_mask = r_mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask    <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_mask <= n_mask;
            if (emit) begin
                r_out_vld <= 1'b1;
            end else if (o_dot.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_base_row <= ld_row;
            r_base_col <= ld_col;
        end
        if (emit) begin
            r_dot_row <= dot_r[9:0];
            r_dot_col <= dot_c[9:0];
            r_band    <= band;
            r_last    <= (rest == '0);
        end
    end

    assign o_dot.valid    = r_out_vld;
    assign o_dot.dot_row  = r_dot_row;
    assign o_dot.dot_col  = r_dot_col;
    assign o_dot.band     = r_band;
    assign o_dot.last_dot = r_last;

endmodule
`default_nettype wire

// ===== src/plot_marker_rasterizer_unit.sv =====
// Plot marker rasterizer: top level with the marker shape register.
//
// Each accepted point word turns into the on-page dot words of the configured
// marker (square, x mark, single point, plus, 5x5 box outline), in pattern
// order, with last_dot set on the final kept dot. The dot walker emits one dot
// word per cycle while the output is not stalled and holds a point for all of
// its kept dots: 1 to 20 (box outline). A point word is taken every cycle while
// the walker keeps up; a repeated point, an unused shape code or a marker
// wholly off the page yields no dot word. A point word passes the input
// register and the walker's dot mask before its first dot word leaves the
// output register. Write marker_shape only while the block is idle.
`default_nettype none
module plot_marker_rasterizer_unit #(
    parameter int PLOT_HEIGHT = pmr_pkg::C_PLOT_HEIGHT,
    parameter int TOP_MARGIN  = pmr_pkg::C_TOP_MARGIN,
    parameter int LEFT_MARGIN = pmr_pkg::C_LEFT_MARGIN,
    parameter int BAND_ROWS   = pmr_pkg::C_BAND_ROWS,
    parameter int BAND_COUNT  = pmr_pkg::C_BAND_COUNT,
    parameter int COL_UNITS   = pmr_pkg::C_COL_UNITS
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_cfg_we,
    input  wire  [2:0] i_cfg_data,
    pmr_pt_if.sink     i_pt,
    pmr_dot_if.source  o_dot
);
    import pmr_pkg::*;

    t_shape   r_shape;
    logic     pt_vld;
    logic     pt_rdy;
    t_pt_word pt_word;

    // Marker shape register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shape <= SHP_SQUARE;
        end else if (i_cfg_we) begin
            r_shape <= t_shape'(i_cfg_data);
        end
    end

    pmr_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pt    (i_pt),
        .o_vld   (pt_vld),
        .o_word  (pt_word),
        .i_rdy   (pt_rdy)
    );

    pmr_dot_walker #(
        .PLOT_HEIGHT (PLOT_HEIGHT),
        .TOP_MARGIN  (TOP_MARGIN),
        .LEFT_MARGIN (LEFT_MARGIN),
        .BAND_ROWS   (BAND_ROWS),
        .BAND_COUNT  (BAND_COUNT),
        .COL_UNITS   (COL_UNITS)
    ) u_walk (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_shape (r_shape),
        .i_vld   (pt_vld),
        .i_word  (pt_word),
        .o_rdy   (pt_rdy),
        .o_dot   (o_dot)
    );

endmodule
`default_nettype wire

// ===== tb/pmr_dot_check.sv =====
// Watches the point and dot channels, predicts each point's marker dots and compares them.
`timescale 1ns / 100ps
module pmr_dot_check
    import pmr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [2:0] i_cfg_data,
    pmr_pt_if          i_pt,
    pmr_dot_if         i_dot,
    output int         o_fail_count,
    output int         o_dots_due
);

    // Page limits, both inclusive
    localparam int ROW_LIMIT = C_BAND_ROWS * C_BAND_COUNT;
    localparam int COL_LIMIT = C_COL_UNITS * C_COL_FACTOR;

    typedef struct packed {
        logic [9:0] row;
        logic [9:0] col;
        logic [1:0] band;
        logic       last;
    } dot_t;

    dot_t               dots_due[$];
    logic [2:0]         shape_q;
    logic signed [11:0] last_row;
    logic signed [11:0] last_col;
    int                 fails;

    // Expand one point into the dots it should produce, in emission order
    function automatic void rasterize_point(input logic signed [11:0] row,
                                            input logic signed [11:0] col,
                                            input logic first);
        int   n;
        int   dr;
        int   dc;
        int   r;
        int   c;
        bit   have;
        dot_t held;
        dot_t d;
        logic same;

        same     = (row == last_row) && (col == last_col);
        last_row = row;
        last_col = col;
        if (!first && same) return;

        case (shape_q)
            SHP_SQUARE: n = 9;
            SHP_XMARK:  n = 5;
            SHP_POINT:  n = 1;
            SHP_PLUS:   n = 5;
            SHP_BOX:    n = 20;
            default:    n = 0;
        endcase

        have = 1'b0;
        held = '0;
        for (int k = 0; k < n; k++) begin
            dr = 0;
            dc = 0;
            case (shape_q)
                SHP_SQUARE: begin
                    dr = k / 3 - 1;
                    dc = k % 3 - 1;
                end
                SHP_XMARK: begin
                    if (k < 4) begin
                        dr = (k < 2) ? 1 : -1;
                        dc = (k % 2) ? 1 : -1;
                    end
                end
                SHP_PLUS: begin
                    dr = (k == 2) ? 1 : (k == 3) ? -1 : 0;
                    dc = (k == 0) ? 1 : (k == 1) ? -1 : 0;
                end
                SHP_BOX: begin
                    // left/right sides first, then top/bottom rows; corners repeat
                    if (k < 10) begin
                        dr = k / 2 - 2;
                        dc = (k % 2) ? 2 : -2;
                    end else begin
                        dr = ((k - 10) % 2) ? -2 : 2;
                        dc = (k - 10) / 2 - 2;
                    end
                end
                default: ;
            endcase

            // vertical flip plus margins; drop anything off the page
            r = C_PLOT_HEIGHT - (int'(row) + dr) + C_TOP_MARGIN;
            c = int'(col) + dc + C_LEFT_MARGIN;
            if (r < 0 || r > ROW_LIMIT || c < 0 || c > COL_LIMIT) continue;

            d.row  = 10'(r);
            d.col  = 10'(c);
            d.band = (r < C_BAND_ROWS) ? 2'd0 : (r < 2 * C_BAND_ROWS) ? 2'd1 : 2'd2;
            d.last = 1'b0;
            if (have) dots_due.push_back(held);
            held = d;
            have = 1'b1;
        end
        if (have) begin
            held.last = 1'b1;
            dots_due.push_back(held);
        end
    endfunction

    // Track config, check dot words, then predict from point words
    always @(posedge i_clk) begin
        dot_t want;
        if (!i_rst_n) begin
            dots_due.delete();
            shape_q  = SHP_SQUARE;
            last_row = '0;
            last_col = '0;
        end else begin
            if (i_cfg_we) shape_q = i_cfg_data;

            if (i_dot.valid && i_dot.ready) begin
                if (dots_due.size() == 0) begin
                    $error("unexpected dot word: row %0d col %0d band %0d last %0d",
                           i_dot.dot_row, i_dot.dot_col, i_dot.band, i_dot.last_dot);
                    fails++;
                end else begin
                    want = dots_due.pop_front();
                    if (i_dot.dot_row !== want.row) begin
                        $error("dot_row: expected %0d, got %0d", want.row, i_dot.dot_row);
                        fails++;
                    end
                    if (i_dot.dot_col !== want.col) begin
                        $error("dot_col: expected %0d, got %0d", want.col, i_dot.dot_col);
                        fails++;
                    end
                    if (i_dot.band !== want.band) begin
                        $error("band: expected %0d, got %0d", want.band, i_dot.band);
                        fails++;
                    end
                    if (i_dot.last_dot !== want.last) begin
                        $error("last_dot: expected %0d, got %0d", want.last, i_dot.last_dot);
                        fails++;
                    end
                end
            end

            if (i_pt.valid && i_pt.ready)
                rasterize_point(i_pt.point_row, i_pt.point_col, i_pt.first_point);
        end
        o_dots_due   <= dots_due.size();
        o_fail_count <= fails;
    end

    initial begin
        fails        = 0;
        o_fail_count = 0;
        o_dots_due   = 0;
    end

endmodule

// ===== tb/tb.sv =====
// Top of the marker rasterizer testbench: clock, reset, point and config stimulus, verdict.
`timescale 1ns / 100ps
module tb;
    import pmr_pkg::*;

    // Spare shape codes that must draw nothing
    localparam logic [2:0] SHP_SPARE_LO  = 3'd5;
    localparam logic [2:0] SHP_SPARE_MID = 3'd6;
    localparam logic [2:0] SHP_SPARE_HI  = 3'd7;

    // Point coordinates whose center dot lands exactly on a page edge
    localparam int ROW_TOP_EDGE    = C_PLOT_HEIGHT + C_TOP_MARGIN;
    localparam int ROW_BOTTOM_EDGE = ROW_TOP_EDGE - C_BAND_ROWS * C_BAND_COUNT;
    localparam int COL_LEFT_EDGE   = -C_LEFT_MARGIN;
    localparam int COL_RIGHT_EDGE  = C_COL_UNITS * C_COL_FACTOR - C_LEFT_MARGIN;

    localparam int PHASE_COUNT  = 10;
    localparam int PHASE_POINTS = 27;
    localparam int SETTLE       = 10;
    localparam int QUIET_LIMIT  = 1000;

    localparam logic [2:0] RUN_SHAPES [PHASE_COUNT] = '{
        SHP_BOX, SHP_SQUARE, SHP_PLUS, SHP_XMARK, SHP_POINT,
        SHP_SPARE_HI, SHP_BOX, SHP_SPARE_LO, SHP_SQUARE, SHP_SPARE_MID};

    // Directed points: reset-value repeat, field extremes, page edges, band edges
    localparam int DIR_COUNT = 19;
    localparam int DIR_ROW [DIR_COUNT] = '{
        0, 0, 0, 0, -2048, 2047, -2048, 2047,
        ROW_TOP_EDGE, ROW_BOTTOM_EDGE, 200, 200, ROW_TOP_EDGE, ROW_BOTTOM_EDGE,
        273, 17, 17, -1, 1365};
    localparam int DIR_COL [DIR_COUNT] = '{
        0, 0, 0, 0, -2048, 2047, 2047, -2048,
        100, 100, COL_LEFT_EDGE, COL_RIGHT_EDGE, COL_LEFT_EDGE, COL_RIGHT_EDGE,
        300, 300, 300, -1, -1366};
    localparam bit DIR_FIRST [DIR_COUNT] = '{
        0, 1, 0, 1, 1, 0, 0, 0,
        1, 0, 0, 0, 0, 0,
        0, 0, 0, 0, 1};

    logic       clk = 1'b0;
    logic       rst_n;
    logic       cfg_we;
    logic [2:0] cfg_data;
    bit         calm;
    int         fail_count;
    int         dots_due;

    pmr_pt_if  pt_bus ();
    pmr_dot_if dot_bus ();

    always #1 clk = ~clk;

    plot_marker_rasterizer_unit i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data),
        .i_pt       (pt_bus),
        .o_dot      (dot_bus)
    );

    pmr_dot_check i_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_data   (cfg_data),
        .i_pt         (pt_bus),
        .i_dot        (dot_bus),
        .o_fail_count (fail_count),
        .o_dots_due   (dots_due)
    );

    // Coordinate mostly around the page, some on its edges, some anywhere
    function automatic logic [11:0] pick_coord(input int lo, input int hi);
        int sel;
        int v;
        sel = $urandom_range(0, 9);
        if (sel < 6)
            v = lo - 3 + int'($urandom_range(0, hi - lo + 6));
        else if (sel < 8)
            v = ((sel == 6) ? lo : hi) + int'($urandom_range(0, 8)) - 4;
        else
            v = int'($urandom_range(0, 4095));
        return 12'(v);
    endfunction

    // Offer one point word after a random gap, return at the accepting edge
    task automatic send_point(input logic [11:0] row, input logic [11:0] col,
                              input logic first);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            pt_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pt_bus.valid       <= 1'b1;
        pt_bus.point_row   <= row;
        pt_bus.point_col   <= col;
        pt_bus.first_point <= first;
        do @(posedge clk); while (!(pt_bus.valid && pt_bus.ready));
    endtask

    // Stop offering points, wait for every pending dot, then let the pipe settle
    task automatic drain_dots();
        pt_bus.valid <= 1'b0;
        do @(posedge clk); while (dots_due != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_shape(input logic [2:0] shape);
        drain_dots();
        cfg_we   <= 1'b1;
        cfg_data <= shape;
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    // Dot sink: random stall before each word, with calm stretches
    initial begin
        int stall;
        dot_bus.ready <= 1'b0;
        do @(posedge clk); while (!rst_n);
        forever begin
            stall = calm ? 0 : $urandom_range(0, 15);
            if (stall > 0) begin
                dot_bus.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            dot_bus.ready <= 1'b1;
            do @(posedge clk); while (!(dot_bus.valid && dot_bus.ready));
        end
    end

    // Watchdog: too long without any word moving on either channel
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge clk);
            if ((pt_bus.valid && pt_bus.ready) || (dot_bus.valid && dot_bus.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb: FAIL");
        $finish;
    end

    // Main stimulus
    initial begin
        int          sent;
        int          set_len;
        logic [11:0] row;
        logic [11:0] col;
        logic        first;

        calm               = 1'b0;
        rst_n              <= 1'b0;
        cfg_we             <= 1'b0;
        cfg_data           <= '0;
        pt_bus.valid       <= 1'b0;
        pt_bus.point_row   <= '0;
        pt_bus.point_col   <= '0;
        pt_bus.first_point <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed points under the reset shape (square)
        for (int i = 0; i < DIR_COUNT; i++)
            send_point(12'(DIR_ROW[i]), 12'(DIR_COL[i]), DIR_FIRST[i]);

        // random plot sets, one shape per phase
        row = '0;
        col = '0;
        for (int p = 0; p < PHASE_COUNT; p++) begin
            set_shape(RUN_SHAPES[p]);
            calm = (p % 4 == 3);
            sent = 0;
            while (sent < PHASE_POINTS) begin
                set_len = $urandom_range(1, 8);
                for (int j = 0; j < set_len && sent < PHASE_POINTS; j++) begin
                    // occasional repeat of the last point inside a set
                    if (!(j > 0 && $urandom_range(0, 4) == 0)) begin
                        row = pick_coord(ROW_BOTTOM_EDGE, ROW_TOP_EDGE);
                        col = pick_coord(COL_LEFT_EDGE, COL_RIGHT_EDGE);
                    end
                    first = (j == 0);
                    if ($urandom_range(0, 9) == 0) first = ~first;
                    send_point(row, col, first);
                    sent++;
                end
            end
        end

        calm = 1'b0;
        drain_dots();
        if (fail_count == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
